/* rtl/slis_pkg.sv */
// Shared types and constants for the sorted list block.
package slis_pkg;

  localparam int VALUE_W          = 32;
  localparam int OP_W             = 2;
  localparam int POS_W            = 5;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [POS_W-1:0] POS_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Update strobes broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

/* rtl/slis_cell.sv */
// One storage cell of the sorted row: compares against the operand and shifts.
module slis_cell import slis_pkg::*; (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      used,
  input  logic                      prev_lt,
  input  logic signed [VALUE_W-1:0] prev_entry,
  input  logic signed [VALUE_W-1:0] next_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      lt,
  output logic                      first_eq
);

  assign lt       = used && (entry < value);
  // The row is ascending, so the first match follows a smaller entry.
  assign first_eq = used && (entry == value) && prev_lt;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!lt) begin
        entry <= prev_lt ? value : prev_entry;
      end
    end else if (ctrl.rem) begin
      if (!lt) begin
        entry <= next_entry;
      end
    end
  end

endmodule

/* rtl/sorted_list_insert_search_remove.sv */
// Sorted list top level: a row of compare-and-shift cells with a result register.
// The result appears on the master side in the cycle after an input transaction is accepted.
// Throughput: one transaction per cycle; every cell compares and shifts in the same cycle.
// Input is stalled only while a result waits and the master side is not ready.
// Reset (rst, synchronous, active high) empties the list and drops any pending result.
// Entries carry no reset; only positions below the count are ever compared.
module sorted_list_insert_search_remove import slis_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op [1:0], value [33:2], zero fill above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // ok [0], position [5:1], entry_count [10:6], zero fill
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                      accept;
  op_t                       op;
  logic signed [VALUE_W-1:0] value;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      full;
  logic                      found;
  logic [IW-1:0]             pos_idx;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] entry    [CAPACITY];
  logic [CAPACITY-1:0]       lt;
  logic [CAPACITY-1:0]       first_eq;

  logic                      ok;
  logic [POS_W-1:0]          position;
  logic [COUNT_W-1:0]        entry_count;

  logic                      res_ok;
  logic [POS_W-1:0]          res_pos;
  logic [CW+COUNT_W-1:0]     count_ext;
  logic [IW+POS_W-1:0]       pos_ext;

  // Decode the transaction; accept whenever the result slot frees up.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tdata[OP_W-1:0]);
  assign value    = s_tdata[OP_W+VALUE_W-1:OP_W];

  assign full  = (count == CW'(CAPACITY));
  assign found = |first_eq;

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    case (op)
      OP_INSERT: ctrl.ins = accept && !full;
      OP_REMOVE: ctrl.rem = accept && found;
      default:   ;
    endcase
  end

  // The row: each cell sees its neighbors' entries and the left neighbor's compare.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      prev_lt;
    logic signed [VALUE_W-1:0] prev_entry;
    logic signed [VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = value;
    end else begin : g_mid
      assign prev_lt    = lt[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    slis_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (value),
      .used       (count > CW'(i)),
      .prev_lt    (prev_lt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entry[i]),
      .lt         (lt[i]),
      .first_eq   (first_eq[i])
    );
  end

  // Encode the single matching cell into its index.
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_eq[i]) begin
        pos_idx = pos_idx | IW'(i);
      end
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, pos_idx};

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    res_ok  = 1'b0;
    res_pos = POS_NONE;
    case (op)
      OP_INSERT: res_ok = !full;
      OP_REMOVE: res_ok = found;
      OP_SEARCH: begin
        res_ok = found;
        if (found) begin
          res_pos = pos_ext[POS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // Hold the count; load the result register on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok          <= res_ok;
      position    <= res_pos;
      entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {5'd0, entry_count, position, ok};

  // Checks on the row and the count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first_eq))
    else $error("more than one first match");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.rem |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink the count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transaction produced no result");

endmodule
